>>> sv/upload_frame_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// upload_frame_decoder_top_defines
// Assertion macros used by the frame decoder top-level RTL.
// ----------------------------------------------------------------------------
`ifndef UPLOAD_FRAME_DECODER_TOP_DEFINES_SVH
`define UPLOAD_FRAME_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while in reset
`define UFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset
`define UFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Types and constants for the upload frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ufd_pkg;

    localparam int POS_W = 17;

    localparam logic [POS_W-1:0] HDR_BYTES      = 17'd33;
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = 17'd34;  // header plus sum byte
    localparam logic [POS_W-1:0] TOTAL_LAST     = 17'd4;
    localparam logic [POS_W-1:0] INDEX_LAST     = 17'd8;
    localparam logic [POS_W-1:0] CSUM_LAST      = 17'd12;
    localparam logic [POS_W-1:0] MODEL_FIRST    = 17'd13;
    localparam logic [POS_W-1:0] MODEL_BYTES    = 17'd16;
    localparam logic [POS_W-1:0] DOWN_LAST      = 17'd30;

    typedef enum logic [1:0] {
        KIND_MODEL   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TRUNCATED = 2'd1,
        STAT_BAD_SUM   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  byte_in;
        logic        frame_start;
        logic [15:0] buffer_length;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_out;
        logic [7:0]  cmd_code;
        logic [31:0] total_packets;
        logic [31:0] packet_number;
        logic [31:0] sender_checksum;
        logic [15:0] down_length;
        logic [15:0] data_length;
        logic [16:0] frame_bytes;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

>>> sv/ufd_if.sv
// ----------------------------------------------------------------------------
// ufd_in_if / ufd_out_if
// Valid/ready channels carrying frame bytes in and decoded items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_in;
    logic        frame_start;
    logic [15:0] buffer_length;

    modport source (output valid, output byte_in, output frame_start,
                    output buffer_length, input ready);
    modport sink   (input valid, input byte_in, input frame_start,
                    input buffer_length, output ready);
endinterface

interface ufd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [7:0]  cmd_code;
    logic [31:0] total_packets;
    logic [31:0] packet_number;
    logic [31:0] sender_checksum;
    logic [15:0] down_length;
    logic [15:0] data_length;
    logic [16:0] frame_bytes;
    logic [1:0]  status;

    modport source (output valid, output kind, output byte_out, output cmd_code,
                    output total_packets, output packet_number,
                    output sender_checksum, output down_length,
                    output data_length, output frame_bytes, output status,
                    input ready);
    modport sink   (input valid, input kind, input byte_out, input cmd_code,
                    input total_packets, input packet_number,
                    input sender_checksum, input down_length,
                    input data_length, input frame_bytes, input status,
                    output ready);
endinterface

`default_nettype wire

>>> sv/upload_frame_decoder_top.sv
// An accepted item waits in the input register; its result, if any, is registered
// when the stage advances. Throughput: one item per cycle while the result register
// is not stalled; the per-byte decode between the input and result registers sets this.
// Items that cause no result still pass through the input register.
// Reset (i_rst_n low, synchronous) empties both registers and leaves the
// parser waiting for a frame start.
// ----------------------------------------------------------------------------
// upload_frame_decoder_top
// Byte-serial deframer: input register, per-byte decode, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "upload_frame_decoder_top_defines.svh"

module upload_frame_decoder_top
    import ufd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ufd_in_if.sink    i_frm,
    ufd_out_if.source o_res
);

    logic     r_in_valid;
    t_in_item r_in;
    logic     r_out_valid;
    t_result  r_out;

    logic     adv;
    logic     in_ready;
    logic     res_valid;
    t_result  res;

    // stage moves when the result register is free or being drained
    assign adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || adv;
    assign i_frm.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_frm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_frm.valid) begin
            r_in.byte_in       <= i_frm.byte_in;
            r_in.frame_start   <= i_frm.frame_start;
            r_in.buffer_length <= i_frm.buffer_length;
        end
    end

    ufd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid <= adv && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.kind            = r_out.kind;
    assign o_res.byte_out        = r_out.byte_out;
    assign o_res.cmd_code        = r_out.cmd_code;
    assign o_res.total_packets   = r_out.total_packets;
    assign o_res.packet_number   = r_out.packet_number;
    assign o_res.sender_checksum = r_out.sender_checksum;
    assign o_res.down_length     = r_out.down_length;
    assign o_res.data_length     = r_out.data_length;
    assign o_res.frame_bytes     = r_out.frame_bytes;
    assign o_res.status          = r_out.status;

    `UFD_ASSERT_NOW(a_len_only_ok, r_out_valid && r_out.status != STAT_OK, r_out.frame_bytes == '0, "frame length given on a failed frame")
    `UFD_ASSERT_NOW(a_ok_len_min, r_out_valid && r_out.kind == KIND_END && r_out.status == STAT_OK, r_out.frame_bytes >= FRAME_OVERHEAD, "ok frame shorter than header")
    `UFD_ASSERT_NOW(a_byte_clean, r_out_valid && r_out.kind != KIND_END, r_out.cmd_code == '0 && r_out.status == STAT_OK && r_out.frame_bytes == '0, "byte item carries header fields")
    `UFD_ASSERT_NEXT(a_stall_hold, r_out_valid && !o_res.ready && r_in_valid, r_in_valid && $stable(r_in), "held item lost while result stalled")

endmodule

`default_nettype wire

>>> sv/ufd_parser.sv
// ----------------------------------------------------------------------------
// ufd_parser
// Frame state (position, running sum, captured header) and per-byte decode.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_parser
    import ufd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire t_in_item i_item,
    output logic          o_res_valid,
    output t_result       o_res
);

    logic             r_active, n_active;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_avail, n_avail;
    logic [7:0]       r_cmd, n_cmd;
    logic [31:0]      r_total, n_total;
    logic [31:0]      r_index, n_index;
    logic [31:0]      r_csum, n_csum;
    logic [15:0]      r_down, n_down;
    logic [15:0]      r_dlen, n_dlen;

    logic             fs;
    logic [7:0]       b;
    logic [POS_W-1:0] pos_e;

    always_comb begin
        fs    = i_item.frame_start;
        b     = i_item.byte_in;
        // frame start wipes the frame before this byte is taken as byte 0
        pos_e     = fs ? '0 : r_pos;
        n_pos     = pos_e;
        n_sum     = fs ? '0 : r_sum;
        n_active  = fs | r_active;
        n_avail   = fs ? i_item.buffer_length : r_avail;
        n_cmd     = fs ? '0 : r_cmd;
        n_total   = fs ? '0 : r_total;
        n_index   = fs ? '0 : r_index;
        n_csum    = fs ? '0 : r_csum;
        n_down    = fs ? '0 : r_down;
        n_dlen    = fs ? '0 : r_dlen;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (n_active) begin
            if (pos_e < HDR_BYTES) begin
                if (pos_e == '0) begin
                    n_cmd = b;
                end else if (pos_e <= TOTAL_LAST) begin
                    n_total = {n_total[23:0], b};
                end else if (pos_e <= INDEX_LAST) begin
                    n_index = {n_index[23:0], b};
                end else if (pos_e <= CSUM_LAST) begin
                    n_csum = {n_csum[23:0], b};
                end else if (pos_e < MODEL_FIRST + MODEL_BYTES) begin
                    o_res_valid    = 1'b1;
                    o_res.kind     = KIND_MODEL;
                    o_res.byte_out = b;
                end else if (pos_e <= DOWN_LAST) begin
                    n_down = {n_down[7:0], b};
                end else begin
                    n_dlen = {n_dlen[7:0], b};
                end
                n_sum = n_sum + b;
                n_pos = pos_e + 1'b1;
                // length known: check the buffer holds the whole frame
                if (n_pos == HDR_BYTES &&
                    {1'b0, n_avail} < FRAME_OVERHEAD + {1'b0, n_dlen}) begin
                    o_res_valid           = 1'b1;
                    o_res.kind            = KIND_END;
                    o_res.cmd_code        = n_cmd;
                    o_res.total_packets   = n_total;
                    o_res.packet_number   = n_index;
                    o_res.sender_checksum = n_csum;
                    o_res.down_length     = n_down;
                    o_res.data_length     = n_dlen;
                    o_res.status          = STAT_TRUNCATED;
                    n_active              = 1'b0;
                end
            end else if (pos_e < HDR_BYTES + {1'b0, n_dlen}) begin
                o_res_valid    = 1'b1;
                o_res.kind     = KIND_PAYLOAD;
                o_res.byte_out = b;
                n_sum          = n_sum + b;
                n_pos          = pos_e + 1'b1;
            end else begin
                // sum byte
                o_res_valid           = 1'b1;
                o_res.kind            = KIND_END;
                o_res.cmd_code        = n_cmd;
                o_res.total_packets   = n_total;
                o_res.packet_number   = n_index;
                o_res.sender_checksum = n_csum;
                o_res.down_length     = n_down;
                o_res.data_length     = n_dlen;
                if (n_sum == b) begin
                    o_res.status      = STAT_OK;
                    o_res.frame_bytes = FRAME_OVERHEAD + {1'b0, n_dlen};
                end else begin
                    o_res.status      = STAT_BAD_SUM;
                end
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_adv) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_avail <= n_avail;
            r_cmd   <= n_cmd;
            r_total <= n_total;
            r_index <= n_index;
            r_csum  <= n_csum;
            r_down  <= n_down;
            r_dlen  <= n_dlen;
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for upload_frame_decoder_top. Frames are built byte
// by byte and pushed through the input channel. Each accepted byte runs
// through a local decoder that predicts the model, payload and frame-end
// items. Every item that leaves the block is checked against the oldest
// prediction. Directed frames come first, then random traffic under four
// idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import ufd_pkg::*;

    localparam int          PER_PHASE    = 450;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ufd_in_if  frm_if ();
    ufd_out_if res_if ();

    upload_frame_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frm   (frm_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // decoder state
    logic [16:0] dec_pos;
    logic [7:0]  dec_sum;
    logic        dec_active;
    logic [15:0] dec_avail;
    logic [7:0]  dec_cmd;
    logic [31:0] dec_total;
    logic [31:0] dec_index;
    logic [31:0] dec_word;
    logic [15:0] dec_down;
    logic [15:0] dec_dlen;

    t_result     pending_results[$];
    t_result     oldest_want;
    logic [7:0]  frame_buf[$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned items_sent     = 0;
    int unsigned items_parsed   = 0;
    int unsigned frame_starts   = 0;
    int unsigned results_seen   = 0;
    int unsigned ends_seen[3]   = '{0, 0, 0};
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    function automatic t_result frame_end(input t_status st);
        t_result r;
        r                 = '0;
        r.kind            = KIND_END;
        r.cmd_code        = dec_cmd;
        r.total_packets   = dec_total;
        r.packet_number   = dec_index;
        r.sender_checksum = dec_word;
        r.down_length     = dec_down;
        r.data_length     = dec_dlen;
        r.frame_bytes     = (st == STAT_OK) ? FRAME_OVERHEAD + {1'b0, dec_dlen} : '0;
        r.status          = st;
        dec_active        = 1'b0;
        return r;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fs,
                                        input logic [15:0] blen);
        t_result r;
        logic    emit;
        r    = '0;
        emit = 1'b0;
        if (fs) begin
            dec_pos    = '0;
            dec_sum    = '0;
            dec_cmd    = '0;
            dec_total  = '0;
            dec_index  = '0;
            dec_word   = '0;
            dec_down   = '0;
            dec_dlen   = '0;
            dec_active = 1'b1;
            dec_avail  = blen;
        end
        if (!dec_active) return;
        items_parsed++;
        if (dec_pos < HDR_BYTES) begin
            if (dec_pos == 0)
                dec_cmd = b;
            else if (dec_pos <= TOTAL_LAST)
                dec_total = {dec_total[23:0], b};
            else if (dec_pos <= INDEX_LAST)
                dec_index = {dec_index[23:0], b};
            else if (dec_pos <= CSUM_LAST)
                dec_word = {dec_word[23:0], b};
            else if (dec_pos < MODEL_FIRST + MODEL_BYTES) begin
                r.kind     = KIND_MODEL;
                r.byte_out = b;
                emit       = 1'b1;
            end else if (dec_pos <= DOWN_LAST)
                dec_down = {dec_down[7:0], b};
            else
                dec_dlen = {dec_dlen[7:0], b};
            dec_sum = dec_sum + b;
            dec_pos = dec_pos + 1'b1;
            // length now known: short buffer ends the frame straight away
            if (dec_pos == HDR_BYTES &&
                {1'b0, dec_avail} < FRAME_OVERHEAD + {1'b0, dec_dlen}) begin
                r    = frame_end(STAT_TRUNCATED);
                emit = 1'b1;
            end
        end else if (dec_pos < HDR_BYTES + {1'b0, dec_dlen}) begin
            r.kind     = KIND_PAYLOAD;
            r.byte_out = b;
            emit       = 1'b1;
            dec_sum    = dec_sum + b;
            dec_pos    = dec_pos + 1'b1;
        end else begin
            r    = frame_end((dec_sum == b) ? STAT_OK : STAT_BAD_SUM);
            emit = 1'b1;
        end
        if (emit) pending_results.push_back(r);
    endfunction

    // ---- input side --------------------------------------------------------

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic fs, input logic [15:0] blen);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            frm_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        frm_if.valid         <= 1'b1;
        frm_if.byte_in       <= b;
        frm_if.frame_start   <= fs;
        frm_if.buffer_length <= blen;
        @(posedge i_clk);
        while (!frm_if.ready) @(posedge i_clk);
        decode_byte(b, fs, blen);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_noise(input int count);
        for (int k = 0; k < count; k++)
            send_item(8'($urandom), 1'b0, 16'($urandom));
    endtask

    task automatic build_frame(input logic [7:0] cmd, input logic [31:0] total,
                               input logic [31:0] index, input logic [31:0] word,
                               input logic [15:0] down, input logic [15:0] dlen,
                               input t_fill fill, input logic complete,
                               input logic [7:0] sum_delta);
        logic [7:0] sum;
        frame_buf.delete();
        frame_buf.push_back(cmd);
        for (int k = 3; k >= 0; k--) frame_buf.push_back(total[8*k +: 8]);
        for (int k = 3; k >= 0; k--) frame_buf.push_back(index[8*k +: 8]);
        for (int k = 3; k >= 0; k--) frame_buf.push_back(word[8*k +: 8]);
        for (int k = 0; k < MODEL_BYTES; k++)
            case (fill)
                FILL_ZERO: frame_buf.push_back(8'h00);
                FILL_ONES: frame_buf.push_back(8'hFF);
                default:   frame_buf.push_back(8'($urandom));
            endcase
        frame_buf.push_back(down[15:8]);
        frame_buf.push_back(down[7:0]);
        frame_buf.push_back(dlen[15:8]);
        frame_buf.push_back(dlen[7:0]);
        // header only when the buffer is meant to come up short
        if (complete) begin
            for (int k = 0; k < dlen; k++) frame_buf.push_back(8'($urandom));
            sum = '0;
            foreach (frame_buf[k]) sum = sum + frame_buf[k];
            frame_buf.push_back(sum + sum_delta);
        end
    endtask

    task automatic send_buffer(input logic [15:0] blen, input int count);
        frame_starts++;
        for (int k = 0; k < count; k++)
            send_item(frame_buf[k], k == 0, (k == 0) ? blen : 16'($urandom));
    endtask

    task automatic random_header_frame(input logic [15:0] dlen, input logic complete,
                                       input logic [7:0] sum_delta);
        build_frame(8'($urandom), $urandom, $urandom, $urandom, 16'($urandom), dlen,
                    FILL_RANDOM, complete, sum_delta);
    endtask

    // ---- output side -------------------------------------------------------

    always @(negedge i_clk)
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("unexpected item: kind %0d byte 0x%0h", res_if.kind,
                       res_if.byte_out);
            end else begin
                oldest_want = pending_results.pop_front();
                if (oldest_want.kind == KIND_END) ends_seen[oldest_want.status]++;
                check_field("kind",            oldest_want.kind,            res_if.kind);
                check_field("byte_out",        oldest_want.byte_out,        res_if.byte_out);
                check_field("cmd_code",        oldest_want.cmd_code,        res_if.cmd_code);
                check_field("total_packets",   oldest_want.total_packets,
                            res_if.total_packets);
                check_field("packet_number",   oldest_want.packet_number,
                            res_if.packet_number);
                check_field("sender_checksum", oldest_want.sender_checksum,
                            res_if.sender_checksum);
                check_field("down_length",     oldest_want.down_length,     res_if.down_length);
                check_field("data_length",     oldest_want.data_length,     res_if.data_length);
                check_field("frame_bytes",     oldest_want.frame_bytes,     res_if.frame_bytes);
                check_field("status",          oldest_want.status,          res_if.status);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d items still due", pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---- tests -------------------------------------------------------------

    task automatic test_idle_bytes();
        send_item(8'h00, 1'b0, 16'hFFFF);
        send_item(8'hFF, 1'b0, 16'h0000);
        send_noise(3);
    endtask

    task automatic test_good_frames();
        // minimum frame in an exactly sized buffer, all fields zero
        build_frame(8'h00, '0, '0, '0, 16'h0000, 16'd0, FILL_ZERO, 1'b1, 8'd0);
        send_buffer(16'd34, frame_buf.size());
        build_frame(8'hFF, '1, '1, '1, 16'hFFFF, 16'd2, FILL_ONES, 1'b1, 8'd0);
        send_buffer(16'hFFFF, frame_buf.size());
        random_header_frame(16'd5, 1'b1, 8'd0);
        send_buffer(16'd39, frame_buf.size());
        send_noise(2);
    endtask

    task automatic test_truncation();
        // one byte short of a sum byte
        build_frame(8'h5A, '0, '1, '0, 16'h8001, 16'd0, FILL_RANDOM, 1'b0, 8'd0);
        send_buffer(16'd33, frame_buf.size());
        send_noise(2);
        build_frame(8'hA5, '1, '0, '1, 16'h7FFE, 16'hFFFF, FILL_ZERO, 1'b0, 8'd0);
        send_buffer(16'hFFFF, frame_buf.size());
        random_header_frame(16'd1, 1'b0, 8'd0);
        send_buffer(16'd0, frame_buf.size());
    endtask

    task automatic test_bad_checksum();
        random_header_frame(16'd0, 1'b1, 8'd1);
        send_buffer(16'd34, frame_buf.size());
        random_header_frame(16'd4, 1'b1, 8'h80);
        send_buffer(16'd100, frame_buf.size());
    endtask

    task automatic test_restart();
        random_header_frame(16'd6, 1'b1, 8'd0);
        send_buffer(16'd40, 20);
        random_header_frame(16'd3, 1'b1, 8'd0);
        send_buffer(16'd37, frame_buf.size() - 1);
        random_header_frame(16'd8, 1'b1, 8'd0);
        send_buffer(16'd42, 36);
        random_header_frame(16'd1, 1'b1, 8'd0);
        send_buffer(16'd35, frame_buf.size());
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned need;
        logic [15:0] dlen;
        logic [15:0] blen;
        pick = $urandom_range(0, 99);
        dlen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(25, 400))
                                           : 16'($urandom_range(0, 24));
        need = 34 + dlen;
        case ($urandom_range(0, 2))
            0:       blen = 16'(need);
            1:       blen = 16'(need + $urandom_range(0, 40));
            default: blen = 16'($urandom_range(need, 65535));
        endcase
        if (pick < 60) begin
            random_header_frame(dlen, 1'b1, 8'd0);
            send_buffer(blen, frame_buf.size());
        end else if (pick < 72) begin
            random_header_frame(dlen, 1'b1, 8'($urandom_range(1, 255)));
            send_buffer(blen, frame_buf.size());
        end else if (pick < 84) begin
            dlen = 16'($urandom);
            need = 34 + dlen;
            blen = 16'($urandom_range(0, (need > 65535) ? 65535 : need - 1));
            random_header_frame(dlen, 1'b0, 8'd0);
            send_buffer(blen, frame_buf.size());
            send_noise($urandom_range(0, 4));
        end else if (pick < 93) begin
            // cut short by the next frame start, or by noise parsed as frame bytes
            random_header_frame(dlen, 1'b1, 8'd0);
            send_buffer(blen, $urandom_range(1, frame_buf.size() - 1));
        end else begin
            send_noise($urandom_range(1, 6));
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int unsigned first;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first          = items_parsed;
        while (items_parsed - first < PER_PHASE) random_frame();
    endtask

    initial begin
        frm_if.valid         = 1'b0;
        frm_if.byte_in       = '0;
        frm_if.frame_start   = 1'b0;
        frm_if.buffer_length = '0;
        res_if.ready         = 1'b0;
        dec_pos              = '0;
        dec_sum              = '0;
        dec_active           = 1'b0;
        dec_avail            = '0;
        dec_cmd              = '0;
        dec_total            = '0;
        dec_index            = '0;
        dec_word             = '0;
        dec_down             = '0;
        dec_dlen             = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bytes();
        test_good_frames();
        test_truncation();
        test_bad_checksum();
        test_restart();
        test_random_traffic(0, 0);
        test_random_traffic(49, 0);
        test_random_traffic(0, 49);
        test_random_traffic(26, 26);

        frm_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes (%0d parsed) in %0d buffers across four idling phases.",
                 items_sent, items_parsed, frame_starts);
        $display("Checked %0d items; frame ends: %0d ok, %0d truncated, %0d bad sum.",
                 results_seen, ends_seen[STAT_OK], ends_seen[STAT_TRUNCATED],
                 ends_seen[STAT_BAD_SUM]);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
